@@ rtl/core/chts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chts_pkg - closest-hit triangle stream shared definitions
// Beat types, fixed-point constants, sequencer states and the micro-program.
// ----------------------------------------------------------------------------
package chts_pkg;

  localparam int CW     = 32;       // coordinate width
  localparam int FB     = 16;       // fraction bits
  localparam int IW     = 64;       // intermediate width
  localparam int BW     = FB + 1;   // barycentric width
  localparam int SLOTW  = 5;        // scratch slot address width
  localparam int SLOTS  = 32;
  localparam int PCW    = 6;
  localparam int ADDR_W = 5;

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [IW-1:0] I_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] I_MIN = {1'b1, {(IW-1){1'b0}}};

  // register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;
  localparam logic [2:0] REG_NEAR     = 3'd6;
  localparam logic [2:0] REG_FAR      = 3'd7;

  // scratch slots
  localparam int SL_ORG = 0;
  localparam int SL_DIR = 3;
  localparam int SL_P0  = 6;
  localparam int SL_P1  = 9;
  localparam int SL_P2  = 12;
  localparam int SL_E1  = 15;
  localparam int SL_E2  = 18;
  localparam int SL_S   = 21;
  localparam int SL_H   = 24;
  localparam int SL_Q   = 27;
  localparam int SL_T0  = 30;
  localparam int SL_T1  = 31;
  localparam int SL_A   = 9;    // reuses p1 once edges are formed
  localparam int SL_N   = 10;
  localparam int LOAD_LAST = 14;

  typedef struct packed {
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
    logic [7:0]           material_index;
    logic                 last_triangle;
  } tri_in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] hit_distance;
    logic [BW-1:0]        bary_u;
    logic [BW-1:0]        bary_v;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic [7:0]           material_id;
  } hit_out_t;

  typedef enum logic [2:0] {
    OP_SUB, OP_ADD, OP_MUL, OP_DIV, OP_CHKA, OP_END
  } uop_code_t;

  localparam int DK_U = 0;
  localparam int DK_V = 1;
  localparam int DK_T = 2;

  typedef struct packed {
    uop_code_t        op;
    logic [SLOTW-1:0] a;
    logic [SLOTW-1:0] b;
    logic [SLOTW-1:0] dst;   // divide kind for OP_DIV
  } uop_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ISSUE, S_OPER, S_EXEC, S_FIN, S_ESET, S_OUT
  } state_t;

  localparam int UCODE_LEN = 61;

  function automatic uop_t mk(input uop_code_t op, input int a, input int b, input int d);
    uop_t u;
    u.op  = op;
    u.a   = SLOTW'(a);
    u.b   = SLOTW'(b);
    u.dst = SLOTW'(d);
    return u;
  endfunction

  function automatic uop_t ucode(input logic [PCW-1:0] pc);
    uop_t u;
    case (pc)
      // edges and s
      6'd0:  u = mk(OP_SUB, SL_P1,   SL_P0,   SL_E1);
      6'd1:  u = mk(OP_SUB, SL_P1+1, SL_P0+1, SL_E1+1);
      6'd2:  u = mk(OP_SUB, SL_P1+2, SL_P0+2, SL_E1+2);
      6'd3:  u = mk(OP_SUB, SL_P2,   SL_P0,   SL_E2);
      6'd4:  u = mk(OP_SUB, SL_P2+1, SL_P0+1, SL_E2+1);
      6'd5:  u = mk(OP_SUB, SL_P2+2, SL_P0+2, SL_E2+2);
      6'd6:  u = mk(OP_SUB, SL_ORG,   SL_P0,   SL_S);
      6'd7:  u = mk(OP_SUB, SL_ORG+1, SL_P0+1, SL_S+1);
      6'd8:  u = mk(OP_SUB, SL_ORG+2, SL_P0+2, SL_S+2);
      // h = dir x e2
      6'd9:  u = mk(OP_MUL, SL_DIR+1, SL_E2+2, SL_T0);
      6'd10: u = mk(OP_MUL, SL_DIR+2, SL_E2+1, SL_T1);
      6'd11: u = mk(OP_SUB, SL_T0, SL_T1, SL_H);
      6'd12: u = mk(OP_MUL, SL_DIR+2, SL_E2,   SL_T0);
      6'd13: u = mk(OP_MUL, SL_DIR,   SL_E2+2, SL_T1);
      6'd14: u = mk(OP_SUB, SL_T0, SL_T1, SL_H+1);
      6'd15: u = mk(OP_MUL, SL_DIR,   SL_E2+1, SL_T0);
      6'd16: u = mk(OP_MUL, SL_DIR+1, SL_E2,   SL_T1);
      6'd17: u = mk(OP_SUB, SL_T0, SL_T1, SL_H+2);
      // a = e1 . h
      6'd18: u = mk(OP_MUL, SL_E1,   SL_H,   SL_T0);
      6'd19: u = mk(OP_MUL, SL_E1+1, SL_H+1, SL_T1);
      6'd20: u = mk(OP_ADD, SL_T0, SL_T1, SL_T0);
      6'd21: u = mk(OP_MUL, SL_E1+2, SL_H+2, SL_T1);
      6'd22: u = mk(OP_ADD, SL_T0, SL_T1, SL_A);
      6'd23: u = mk(OP_CHKA, SL_A, SL_A, SL_A);
      // u = (s . h) / a
      6'd24: u = mk(OP_MUL, SL_S,   SL_H,   SL_T0);
      6'd25: u = mk(OP_MUL, SL_S+1, SL_H+1, SL_T1);
      6'd26: u = mk(OP_ADD, SL_T0, SL_T1, SL_T0);
      6'd27: u = mk(OP_MUL, SL_S+2, SL_H+2, SL_T1);
      6'd28: u = mk(OP_ADD, SL_T0, SL_T1, SL_N);
      6'd29: u = mk(OP_DIV, SL_N, SL_A, DK_U);
      // q = s x e1
      6'd30: u = mk(OP_MUL, SL_S+1, SL_E1+2, SL_T0);
      6'd31: u = mk(OP_MUL, SL_S+2, SL_E1+1, SL_T1);
      6'd32: u = mk(OP_SUB, SL_T0, SL_T1, SL_Q);
      6'd33: u = mk(OP_MUL, SL_S+2, SL_E1,   SL_T0);
      6'd34: u = mk(OP_MUL, SL_S,   SL_E1+2, SL_T1);
      6'd35: u = mk(OP_SUB, SL_T0, SL_T1, SL_Q+1);
      6'd36: u = mk(OP_MUL, SL_S,   SL_E1+1, SL_T0);
      6'd37: u = mk(OP_MUL, SL_S+1, SL_E1,   SL_T1);
      6'd38: u = mk(OP_SUB, SL_T0, SL_T1, SL_Q+2);
      // v = (dir . q) / a
      6'd39: u = mk(OP_MUL, SL_DIR,   SL_Q,   SL_T0);
      6'd40: u = mk(OP_MUL, SL_DIR+1, SL_Q+1, SL_T1);
      6'd41: u = mk(OP_ADD, SL_T0, SL_T1, SL_T0);
      6'd42: u = mk(OP_MUL, SL_DIR+2, SL_Q+2, SL_T1);
      6'd43: u = mk(OP_ADD, SL_T0, SL_T1, SL_N);
      6'd44: u = mk(OP_DIV, SL_N, SL_A, DK_V);
      // t = (e2 . q) / a
      6'd45: u = mk(OP_MUL, SL_E2,   SL_Q,   SL_T0);
      6'd46: u = mk(OP_MUL, SL_E2+1, SL_Q+1, SL_T1);
      6'd47: u = mk(OP_ADD, SL_T0, SL_T1, SL_T0);
      6'd48: u = mk(OP_MUL, SL_E2+2, SL_Q+2, SL_T1);
      6'd49: u = mk(OP_ADD, SL_T0, SL_T1, SL_N);
      6'd50: u = mk(OP_DIV, SL_N, SL_A, DK_T);
      default: u = mk(OP_END, 0, 0, 0);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/chts_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chts_ram - generic scratch RAM
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
module chts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

@@ rtl/core/closest_hit_triangle_stream_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// closest_hit_triangle_stream_top - closest-hit ray/triangle tester
// Moller-Trumbore test in signed Q16.16 over a stream of triangles.
// ----------------------------------------------------------------------------
// Usage:
//  - The ray (origin, direction, near and far limit) is written over the APB
//    port; pready is tied high, prdata reads back any register.
//  - Triangles arrive as in_ beats. Each beat is tested and the closest hit
//    is kept. The beat flagged last_triangle also yields one out_ beat with
//    the hit, distance, barycentrics, hit point and material, and the held
//    best is cleared for the next ray.
//  - in_ready is high only while the sequencer is idle. A triangle loads the
//    ray and its vertices into scratch, then runs 23 add/sub ops, a
//    determinant check, 24 multiplies (issue, operand fetch, five steps), up
//    to three divides and one closing step; a zero determinant ends it after
//    the check. A last beat adds an output step, and with a hit three more
//    multiplies for the hit point.
//    The pace is set by the single shared 32x32 multiplier (four partial
//    products per 64-bit multiply) and the one-bit-per-cycle divider.
//  - The result sits in an output register; a stalled receiver holds it,
//    and new triangles are still taken until the next result is ready.
//  - Synchronous reset clears the registers to their reset values and the
//    held best, and empties the output register.
// ----------------------------------------------------------------------------
module closest_hit_triangle_stream_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  chts_pkg::tri_in_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output chts_pkg::hit_out_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [chts_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import chts_pkg::*;

  localparam logic [7:0] MUL_LAST = 8'd4;
  localparam logic [7:0] DIV_LAST = 8'(2 * IW);
  localparam logic signed [CW+1:0] ONE_FX = (CW+2)'(1) <<< FB;

  // configuration
  logic signed [CW-1:0] org_x_r, org_y_r, org_z_r;
  logic signed [CW-1:0] dir_x_r, dir_y_r, dir_z_r;
  logic signed [CW-1:0] near_r, far_r;

  // sequencer
  state_t state_r, state_nxt;
  tri_in_t in_r;
  logic [PCW-1:0] pc_r;
  logic [3:0]     ld_r;
  logic [7:0]     cnt_r;
  uop_t           op_r;
  logic           emit_r;
  logic [1:0]     ek_r;

  // shared unit
  logic [IW-1:0]   mga_r, mgb_r;
  logic            neg_r;
  logic [2*IW-1:0] acc_r;
  logic [IW-1:0]   rem_r;
  logic [2*IW-1:0] dq_r;
  logic signed [CW-1:0] u_r, v_r;

  // best hit
  logic signed [CW-1:0] best_dist_r;
  logic                 any_hit_r;
  logic [BW-1:0]        best_u_r, best_v_r;
  logic [7:0]           best_mat_r;
  logic signed [CW-1:0] px_r, py_r, pz_r;

  logic     out_valid_r;
  hit_out_t out_data_r;

  // scratch RAM
  logic             we;
  logic [SLOTW-1:0] waddr;
  logic [IW-1:0]    wdata;
  logic [IW-1:0]    rda, rdb;
  uop_t             cur;

  function automatic logic signed [IW-1:0] sat_add(input logic signed [IW-1:0] a,
                                                   input logic signed [IW-1:0] b);
    logic signed [IW:0] s;
    s = {a[IW-1], a} + {b[IW-1], b};
    if (s[IW] != s[IW-1]) return s[IW] ? I_MIN : I_MAX;
    return s[IW-1:0];
  endfunction

  function automatic logic signed [IW-1:0] sat_sub(input logic signed [IW-1:0] a,
                                                   input logic signed [IW-1:0] b);
    logic signed [IW:0] s;
    s = {a[IW-1], a} - {b[IW-1], b};
    if (s[IW] != s[IW-1]) return s[IW] ? I_MIN : I_MAX;
    return s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] mag(input logic [IW-1:0] x);
    return x[IW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic signed [CW-1:0] clamp_c(input logic signed [IW-1:0] x);
    if (x > IW'(C_MAX)) return C_MAX;
    if (x < IW'(C_MIN)) return C_MIN;
    return x[CW-1:0];
  endfunction

  assign cur = ucode(pc_r);

  chts_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_scratch (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (cur.a),
    .rdata_a (rda),
    .raddr_b (cur.b),
    .rdata_b (rdb)
  );

  // --- shared unit arithmetic -----------------------------------------------
  logic signed [IW-1:0] addsub_res;
  logic [IW-1:0]        mag_a, mag_b;
  logic [31:0]          pa, pb;
  logic [63:0]          pp;
  logic [2*IW-1:0]      acc_add;
  logic [IW-1:0]        qlo;
  logic signed [IW-1:0] mul_res;
  logic [IW:0]          dtrial;
  logic                 dge;
  logic                 qbig;
  logic signed [IW-1:0] qval64;
  logic signed [CW-1:0] qv;
  logic                 u_ok, v_ok, t_ok;
  logic signed [CW-1:0] org_k, dir_k;
  logic signed [CW-1:0] pt_k;
  logic signed [IW-1:0] load_val;

  always_comb begin
    addsub_res = (cur.op == OP_ADD) ? sat_add(rda, rdb) : sat_sub(rda, rdb);
    mag_a = mag(rda);
    mag_b = mag(rdb);

    pa = cnt_r[0] ? mga_r[63:32] : mga_r[31:0];
    pb = cnt_r[1] ? mgb_r[63:32] : mgb_r[31:0];
    pp = 64'(pa) * 64'(pb);
    case ({1'b0, cnt_r[0]} + {1'b0, cnt_r[1]})
      2'd0:    acc_add = {64'b0, pp};
      2'd1:    acc_add = {32'b0, pp, 32'b0};
      default: acc_add = {pp, 64'b0};
    endcase

    qlo = acc_r[FB+IW-1:FB];
    if (|acc_r[2*IW-1:FB+IW]) begin
      mul_res = neg_r ? I_MIN : I_MAX;
    end else if (neg_r) begin
      mul_res = qlo[IW-1] ? I_MIN : -$signed(qlo);
    end else begin
      mul_res = qlo[IW-1] ? I_MAX : $signed(qlo);
    end

    dtrial = {rem_r, dq_r[2*IW-1]};
    dge    = dtrial >= {1'b0, mgb_r};

    qbig   = dq_r > {{(IW+1){1'b0}}, 1'b1, {(IW-2){1'b0}}};
    qval64 = neg_r ? -$signed(dq_r[IW-1:0]) : $signed(dq_r[IW-1:0]);
    qv     = qbig ? (neg_r ? C_MIN : C_MAX) : clamp_c(qval64);

    u_ok = (qv >= 0) && ((CW+2)'(qv) <= ONE_FX);
    v_ok = (qv >= 0) && (((CW+2)'(qv) + (CW+2)'(u_r)) <= ONE_FX);
    t_ok = (qv >= near_r) && (qv <= best_dist_r);

    case (ek_r)
      2'd0:    begin org_k = org_x_r; dir_k = dir_x_r; end
      2'd1:    begin org_k = org_y_r; dir_k = dir_y_r; end
      default: begin org_k = org_z_r; dir_k = dir_z_r; end
    endcase
    pt_k = clamp_c(sat_add(IW'(org_k), mul_res));

    case (ld_r)
      4'd0:    load_val = IW'(org_x_r);
      4'd1:    load_val = IW'(org_y_r);
      4'd2:    load_val = IW'(org_z_r);
      4'd3:    load_val = IW'(dir_x_r);
      4'd4:    load_val = IW'(dir_y_r);
      4'd5:    load_val = IW'(dir_z_r);
      4'd6:    load_val = IW'(in_r.v0_x);
      4'd7:    load_val = IW'(in_r.v0_y);
      4'd8:    load_val = IW'(in_r.v0_z);
      4'd9:    load_val = IW'(in_r.v1_x);
      4'd10:   load_val = IW'(in_r.v1_y);
      4'd11:   load_val = IW'(in_r.v1_z);
      4'd12:   load_val = IW'(in_r.v2_x);
      4'd13:   load_val = IW'(in_r.v2_y);
      default: load_val = IW'(in_r.v2_z);
    endcase
  end

  logic exec_done;
  assign exec_done = (op_r.op == OP_MUL) ? (cnt_r == MUL_LAST) : (cnt_r == DIV_LAST);

  // --- next state -----------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_LOAD;
      S_LOAD:  if (ld_r == 4'(LOAD_LAST)) state_nxt = S_ISSUE;
      S_ISSUE: state_nxt = S_OPER;
      S_OPER: begin
        case (cur.op)
          OP_SUB, OP_ADD: state_nxt = S_ISSUE;
          OP_MUL, OP_DIV: state_nxt = S_EXEC;
          OP_CHKA:        state_nxt = (rda == '0) ? S_FIN : S_ISSUE;
          default:        state_nxt = S_FIN;
        endcase
      end
      S_EXEC: begin
        if (exec_done) begin
          if (op_r.op == OP_MUL) begin
            if (emit_r) state_nxt = (ek_r == 2'd2) ? S_OUT : S_ESET;
            else        state_nxt = S_ISSUE;
          end else if (op_r.dst == SLOTW'(DK_U)) begin
            state_nxt = u_ok ? S_ISSUE : S_FIN;
          end else if (op_r.dst == SLOTW'(DK_V)) begin
            state_nxt = v_ok ? S_ISSUE : S_FIN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!in_r.last_triangle) state_nxt = S_IDLE;
        else                     state_nxt = any_hit_r ? S_ESET : S_OUT;
      end
      S_ESET:  state_nxt = S_EXEC;
      S_OUT:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // --- outputs --------------------------------------------------------------
  always_comb begin
    in_ready = (state_r == S_IDLE);
    we       = 1'b0;
    waddr    = cur.dst;
    wdata    = addsub_res;
    case (state_r)
      S_LOAD: begin
        we    = 1'b1;
        waddr = SLOTW'(ld_r);
        wdata = load_val;
      end
      S_OPER: begin
        we = (cur.op == OP_ADD) || (cur.op == OP_SUB);
      end
      S_EXEC: begin
        we    = (op_r.op == OP_MUL) && !emit_r && (cnt_r == MUL_LAST);
        waddr = op_r.dst;
        wdata = mul_res;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;

  // --- configuration --------------------------------------------------------
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0; org_y_r <= '0; org_z_r <= '0;
      dir_x_r <= '0; dir_y_r <= '0; dir_z_r <= '0;
      near_r  <= '0;
      far_r   <= C_MAX;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORIGIN_X: org_x_r <= pwdata;
        REG_ORIGIN_Y: org_y_r <= pwdata;
        REG_ORIGIN_Z: org_z_r <= pwdata;
        REG_DIR_X:    dir_x_r <= pwdata;
        REG_DIR_Y:    dir_y_r <= pwdata;
        REG_DIR_Z:    dir_z_r <= pwdata;
        REG_NEAR:     near_r  <= pwdata;
        default:      far_r   <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ORIGIN_X: prdata = org_x_r;
      REG_ORIGIN_Y: prdata = org_y_r;
      REG_ORIGIN_Z: prdata = org_z_r;
      REG_DIR_X:    prdata = dir_x_r;
      REG_DIR_Y:    prdata = dir_y_r;
      REG_DIR_Z:    prdata = dir_z_r;
      REG_NEAR:     prdata = near_r;
      default:      prdata = far_r;
    endcase
  end

  // --- sequencer and datapath -----------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      ld_r        <= '0;
      cnt_r       <= '0;
      emit_r      <= 1'b0;
      ek_r        <= '0;
      best_dist_r <= C_MAX;
      any_hit_r   <= 1'b0;
      best_u_r    <= '0;
      best_v_r    <= '0;
      best_mat_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      // far limit also seeds the best while nothing is held
      if (cfg_wr && cfg_idx == REG_FAR && !any_hit_r) best_dist_r <= pwdata;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r <= in_data;
            ld_r <= '0;
            pc_r <= '0;
          end
        end
        S_LOAD: ld_r <= ld_r + 4'd1;
        S_OPER: begin
          case (cur.op)
            OP_MUL, OP_DIV: begin
              mga_r  <= mag_a;
              mgb_r  <= mag_b;
              neg_r  <= rda[IW-1] ^ rdb[IW-1];
              acc_r  <= '0;
              rem_r  <= '0;
              dq_r   <= {{IW{1'b0}}, mag_a} << FB;
              cnt_r  <= '0;
              op_r   <= cur;
              emit_r <= 1'b0;
            end
            default: pc_r <= pc_r + 1'b1;
          endcase
        end
        S_EXEC: begin
          cnt_r <= cnt_r + 8'd1;
          if (op_r.op == OP_MUL) begin
            acc_r <= acc_r + acc_add;
          end else begin
            rem_r <= dge ? IW'(dtrial - {1'b0, mgb_r}) : dtrial[IW-1:0];
            dq_r  <= {dq_r[2*IW-2:0], dge};
          end
          if (exec_done) begin
            pc_r <= pc_r + 1'b1;
            if (op_r.op == OP_MUL) begin
              if (emit_r) begin
                case (ek_r)
                  2'd0:    px_r <= pt_k;
                  2'd1:    py_r <= pt_k;
                  default: pz_r <= pt_k;
                endcase
                ek_r <= ek_r + 2'd1;
              end
            end else if (op_r.dst == SLOTW'(DK_U)) begin
              u_r <= qv;
            end else if (op_r.dst == SLOTW'(DK_V)) begin
              v_r <= qv;
            end else if (t_ok) begin
              best_dist_r <= qv;
              best_u_r    <= BW'(u_r);
              best_v_r    <= BW'(v_r);
              best_mat_r  <= in_r.material_index;
              any_hit_r   <= 1'b1;
            end
          end
        end
        S_FIN: ek_r <= '0;
        S_ESET: begin
          mga_r  <= mag(IW'(best_dist_r));
          mgb_r  <= mag(IW'(dir_k));
          neg_r  <= best_dist_r[CW-1] ^ dir_k[CW-1];
          acc_r  <= '0;
          cnt_r  <= '0;
          op_r   <= mk(OP_MUL, 0, 0, 0);
          emit_r <= 1'b1;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            if (any_hit_r) begin
              out_data_r.hit          <= 1'b1;
              out_data_r.hit_distance <= best_dist_r;
              out_data_r.bary_u       <= best_u_r;
              out_data_r.bary_v       <= best_v_r;
              out_data_r.point_x      <= px_r;
              out_data_r.point_y      <= py_r;
              out_data_r.point_z      <= pz_r;
              out_data_r.material_id  <= best_mat_r;
            end else begin
              out_data_r <= '0;
            end
            best_dist_r <= far_r;
            any_hit_r   <= 1'b0;
            best_u_r    <= '0;
            best_v_r    <= '0;
            best_mat_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // --- assertions -----------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a triangle while still busy");

  a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE) |-> (pc_r < PCW'(UCODE_LEN)))
    else $error("micro-program counter ran off the end");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.hit) |->
      (out_data_r.hit_distance == '0 && out_data_r.material_id == '0))
    else $error("miss beat carries non-zero fields");

  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && op_r.op == OP_MUL) |-> (cnt_r <= MUL_LAST))
    else $error("multiply step count overrun");

endmodule
`default_nettype wire
